[src/assert_macros.svh]
// assertion macros used by the receiver top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// expression holds at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

[src/msp_rx_pkg.sv]
// shared types and constants for the frame receiver
`default_nettype none

package msp_rx_pkg;

    localparam int DEF_MAX_PAYLOAD = 64;
    localparam int DEF_NUM_PORTS   = 4;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_LT     = 8'h3C;

    localparam logic KIND_OTHER = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // per-port parser state
    typedef enum logic [2:0] {
        PS_IDLE   = 3'd0,
        PS_DOLLAR = 3'd1,
        PS_M      = 3'd2,
        PS_ARROW  = 3'd3,
        PS_SIZE   = 3'd4,
        PS_CMD    = 3'd5
    } pstate_t;

    // controller state
    typedef enum logic [1:0] {
        CS_WAIT_IN,
        CS_DECIDE,
        CS_RD_PRIME,
        CS_RD_LOAD
    } ctl_state_t;

    typedef struct packed {
        logic    capture;
        logic    ps_we;
        pstate_t ps_next;
        logic    load_size;
        logic    load_cmd;
        logic    store_byte;
        logic    emit_pass;
        logic    emit_empty;
        logic    rd_start;
        logic    rd_load;
    } msp_cmd_t;

    typedef struct packed {
        logic    port_ok;
        logic    enable;
        pstate_t ps;
        logic    is_dollar;
        logic    is_m;
        logic    is_lt;
        logic    size_ok;
        logic    fill_more;
        logic    xor_ok;
        logic    size_zero;
        logic    out_free;
        logic    rd_last;
    } msp_sts_t;

endpackage

`default_nettype wire

[src/msp_rx_ram.sv]
// generic single-port ram with registered read
`default_nettype none

module msp_rx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                       wdata,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

`default_nettype wire

[src/msp_rx_ctrl.sv]
// controller state machine: sequences parsing and payload readout
`default_nettype none

module msp_rx_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire msp_rx_pkg::msp_sts_t sts,
    output msp_rx_pkg::msp_cmd_t      cmd
);

    msp_rx_pkg::ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msp_rx_pkg::CS_WAIT_IN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.ps_next   = msp_rx_pkg::PS_IDLE;
        s_axis_tready = 1'b0;

        case (state_reg)
            msp_rx_pkg::CS_WAIT_IN:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = msp_rx_pkg::CS_DECIDE;
                end
            end

            msp_rx_pkg::CS_DECIDE:
            begin
                state_next = msp_rx_pkg::CS_WAIT_IN;
                if (!sts.port_ok)
                begin
                    // byte on a port that does not exist: dropped
                end
                else if (!sts.enable)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit_pass = 1'b1;
                    end
                    else
                    begin
                        state_next = msp_rx_pkg::CS_DECIDE;
                    end
                end
                else
                begin
                    case (sts.ps)
                        msp_rx_pkg::PS_DOLLAR:
                        begin
                            cmd.ps_we   = 1'b1;
                            cmd.ps_next = sts.is_m ? msp_rx_pkg::PS_M : msp_rx_pkg::PS_IDLE;
                        end
                        msp_rx_pkg::PS_M:
                        begin
                            cmd.ps_we   = 1'b1;
                            cmd.ps_next = sts.is_lt ? msp_rx_pkg::PS_ARROW
                                                    : msp_rx_pkg::PS_IDLE;
                        end
                        msp_rx_pkg::PS_ARROW:
                        begin
                            cmd.ps_we = 1'b1;
                            if (sts.size_ok)
                            begin
                                cmd.load_size = 1'b1;
                                cmd.ps_next   = msp_rx_pkg::PS_SIZE;
                            end
                        end
                        msp_rx_pkg::PS_SIZE:
                        begin
                            cmd.ps_we    = 1'b1;
                            cmd.load_cmd = 1'b1;
                            cmd.ps_next  = msp_rx_pkg::PS_CMD;
                        end
                        msp_rx_pkg::PS_CMD:
                        begin
                            if (sts.fill_more)
                            begin
                                cmd.store_byte = 1'b1;
                            end
                            else if (!sts.xor_ok)
                            begin
                                cmd.ps_we = 1'b1;
                            end
                            else if (sts.size_zero)
                            begin
                                // empty payload gives a single result
                                if (sts.out_free)
                                begin
                                    cmd.ps_we      = 1'b1;
                                    cmd.emit_empty = 1'b1;
                                end
                                else
                                begin
                                    state_next = msp_rx_pkg::CS_DECIDE;
                                end
                            end
                            else
                            begin
                                cmd.ps_we    = 1'b1;
                                cmd.rd_start = 1'b1;
                                state_next   = msp_rx_pkg::CS_RD_PRIME;
                            end
                        end
                        default:
                        begin
                            if (sts.is_dollar)
                            begin
                                cmd.ps_we   = 1'b1;
                                cmd.ps_next = msp_rx_pkg::PS_DOLLAR;
                            end
                            else if (sts.out_free)
                            begin
                                cmd.ps_we     = 1'b1;
                                cmd.emit_pass = 1'b1;
                            end
                            else
                            begin
                                state_next = msp_rx_pkg::CS_DECIDE;
                            end
                        end
                    endcase
                end
            end

            msp_rx_pkg::CS_RD_PRIME:
            begin
                // first payload byte is being read from the store
                state_next = msp_rx_pkg::CS_RD_LOAD;
            end

            msp_rx_pkg::CS_RD_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.rd_load = 1'b1;
                    if (sts.rd_last)
                    begin
                        state_next = msp_rx_pkg::CS_WAIT_IN;
                    end
                end
            end

            default:
            begin
                state_next = msp_rx_pkg::CS_WAIT_IN;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/msp_rx_datapath.sv]
// datapath: per-port parser registers, payload store and output register
`default_nettype none

module msp_rx_datapath #(
    parameter int MAX_PAYLOAD = msp_rx_pkg::DEF_MAX_PAYLOAD,
    parameter int NUM_PORTS   = msp_rx_pkg::DEF_NUM_PORTS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,
    input  wire logic [15:0]          s_axis_tdata,
    output logic      [31:0]          m_axis_tdata,
    output logic                      m_axis_tuser,
    output logic                      m_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire msp_rx_pkg::msp_cmd_t cmd,
    output msp_rx_pkg::msp_sts_t      sts
);

    localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int SZ_W   = $clog2(MAX_PAYLOAD + 1);
    localparam int DEPTH  = NUM_PORTS * MAX_PAYLOAD;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                enable_reg;
    logic [1:0]          cap_port_reg;
    logic [7:0]          cap_byte_reg;

    msp_rx_pkg::pstate_t ps_reg   [NUM_PORTS];
    logic [SZ_W-1:0]     size_reg [NUM_PORTS];
    logic [SZ_W-1:0]     fill_reg [NUM_PORTS];
    logic [7:0]          xor_reg  [NUM_PORTS];
    logic [7:0]          hcmd_reg [NUM_PORTS];

    logic [SZ_W-1:0]     rd_idx_reg, rd_idx_next;

    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [1:0]          out_port_reg;
    logic [7:0]          out_cmd_reg;
    logic [6:0]          out_size_reg;
    logic [7:0]          out_byte_reg;
    logic [5:0]          out_idx_reg;
    logic                out_last_reg;

    logic [PIDX_W-1:0]   pidx;
    logic [SZ_W-1:0]     cur_size;
    logic [SZ_W-1:0]     cur_fill;
    logic [ADDR_W-1:0]   base_addr;
    logic [SZ_W-1:0]     ram_offset;
    logic [ADDR_W-1:0]   ram_addr;
    logic [7:0]          ram_rdata;
    logic                rd_last;

    assign pidx     = PIDX_W'(cap_port_reg);
    assign cur_size = size_reg[pidx];
    assign cur_fill = fill_reg[pidx];
    assign rd_last  = (rd_idx_reg == (cur_size - SZ_W'(1)));

    always_comb
    begin
        sts.port_ok   = (4'(cap_port_reg) < 4'(NUM_PORTS));
        sts.enable    = enable_reg;
        sts.ps        = ps_reg[pidx];
        sts.is_dollar = (cap_byte_reg == msp_rx_pkg::CHAR_DOLLAR);
        sts.is_m      = (cap_byte_reg == msp_rx_pkg::CHAR_M);
        sts.is_lt     = (cap_byte_reg == msp_rx_pkg::CHAR_LT);
        sts.size_ok   = ({1'b0, cap_byte_reg} <= 9'(MAX_PAYLOAD));
        sts.fill_more = (cur_fill < cur_size);
        sts.xor_ok    = (xor_reg[pidx] == cap_byte_reg);
        sts.size_zero = (cur_size == '0);
        sts.out_free  = !out_valid_reg || m_axis_tready;
        sts.rd_last   = rd_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            enable_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_port_reg <= s_axis_tdata[1:0];
            cap_byte_reg <= s_axis_tdata[9:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                ps_reg[i]   <= msp_rx_pkg::PS_IDLE;
                size_reg[i] <= '0;
                fill_reg[i] <= '0;
                xor_reg[i]  <= '0;
                hcmd_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.ps_we)
            begin
                ps_reg[pidx] <= cmd.ps_next;
            end
            if (cmd.load_size)
            begin
                size_reg[pidx] <= SZ_W'(cap_byte_reg);
                xor_reg[pidx]  <= cap_byte_reg;
                fill_reg[pidx] <= '0;
            end
            if (cmd.load_cmd)
            begin
                hcmd_reg[pidx] <= cap_byte_reg;
                xor_reg[pidx]  <= xor_reg[pidx] ^ cap_byte_reg;
            end
            if (cmd.store_byte)
            begin
                xor_reg[pidx]  <= xor_reg[pidx] ^ cap_byte_reg;
                fill_reg[pidx] <= cur_fill + SZ_W'(1);
            end
        end
    end

    // readout index; the store address runs one ahead when a byte is taken
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_start)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.rd_load && !rd_last)
        begin
            rd_idx_next = rd_idx_reg + SZ_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
    end

    assign base_addr  = ADDR_W'(pidx) * ADDR_W'(MAX_PAYLOAD);
    assign ram_offset = cmd.store_byte ? cur_fill : rd_idx_next;
    assign ram_addr   = base_addr + ADDR_W'(ram_offset);

    msp_rx_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (cmd.store_byte),
        .addr  (ram_addr),
        .wdata (cap_byte_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_pass || cmd.emit_empty || cmd.rd_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_pass)
        begin
            out_kind_reg <= msp_rx_pkg::KIND_OTHER;
            out_port_reg <= cap_port_reg;
            out_cmd_reg  <= '0;
            out_size_reg <= '0;
            out_byte_reg <= cap_byte_reg;
            out_idx_reg  <= '0;
            out_last_reg <= 1'b1;
        end
        else if (cmd.emit_empty)
        begin
            out_kind_reg <= msp_rx_pkg::KIND_FRAME;
            out_port_reg <= cap_port_reg;
            out_cmd_reg  <= hcmd_reg[pidx];
            out_size_reg <= '0;
            out_byte_reg <= '0;
            out_idx_reg  <= '0;
            out_last_reg <= 1'b1;
        end
        else if (cmd.rd_load)
        begin
            out_kind_reg <= msp_rx_pkg::KIND_FRAME;
            out_port_reg <= cap_port_reg;
            out_cmd_reg  <= hcmd_reg[pidx];
            out_size_reg <= 7'(cur_size);
            out_byte_reg <= ram_rdata;
            out_idx_reg  <= 6'(rd_idx_reg);
            out_last_reg <= rd_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {1'b0, out_idx_reg, out_byte_reg, out_size_reg,
                            out_cmd_reg, out_port_reg};

endmodule

`default_nettype wire

[src/msp_frame_receiver_unit.sv]
// top level of the multi-port serial frame receiver
//
// input stream: one received byte and the port it arrived on per transfer.
// output stream: one result per transfer; tuser marks frame payload versus
// passed-through data, tlast closes each run. payload of a good frame comes
// out as a run of results, an empty payload as one result.
// cfg_wr_en/cfg_wr_data write the parse enable; write only while idle.
// an input byte is first accepted into the capture register, then decided
// against the port's parser state; its result, if any, is loaded into the
// output register when the decision goes through. a completed frame of n
// payload bytes is read from the single-port payload store at one byte a
// cycle while the sink takes them, after a priming state that starts the read.
// the input is taken only in the waiting state, so the next byte waits until
// the decision, and any readout of a good frame, is done.
// a result waiting in the output register does not stop the next byte being
// accepted; when the sink stalls, the block holds in decide or readout until
// the output register frees.
// reset clears every port's parser to idle, empties the output register and
// sets the parse enable; the payload store is not cleared.
`default_nettype none

module msp_frame_receiver_unit #(
    parameter int MAX_PAYLOAD = msp_rx_pkg::DEF_MAX_PAYLOAD,
    parameter int NUM_PORTS   = msp_rx_pkg::DEF_NUM_PORTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,    // msp_enable
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // rx_port[1:0], rx_byte[9:2]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // out_port[1:0], frame_command[9:2],
                                             // frame_size[16:10], out_byte[24:17],
                                             // byte_index[30:25]
    output logic             m_axis_tuser,   // kind
    output logic             m_axis_tlast
);

`include "assert_macros.svh"

    msp_rx_pkg::msp_cmd_t cmd;
    msp_rx_pkg::msp_sts_t sts;

    msp_rx_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    msp_rx_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .NUM_PORTS   (NUM_PORTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .sts           (sts)
    );

    // a result is only loaded into a free output register
    `ASSERT_IMPL(a_load_into_free, (cmd.emit_pass || cmd.emit_empty || cmd.rd_load), sts.out_free, "result loaded over a waiting result")

    // at most one source loads the output register
    `ASSERT_ALWAYS(a_one_source, $onehot0({cmd.emit_pass, cmd.emit_empty, cmd.rd_load}), "several result sources at once")

    // after the final payload byte the block waits for input again
    `ASSERT_NEXT(a_readout_done, (cmd.rd_load && sts.rd_last), s_axis_tready, "input not reopened after frame readout")

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the multi-port serial frame receiver
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import msp_rx_pkg::*;

    localparam int PAYLOAD_MAX   = DEF_MAX_PAYLOAD;
    localparam int PORT_COUNT    = DEF_NUM_PORTS;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX    = 10;
    localparam int OFF_ITEMS     = 30;
    localparam int ON_ITEMS      = 255;

    typedef struct packed {
        logic       kind;
        logic [1:0] port;
        logic [7:0] command;
        logic [6:0] size;
        logic [7:0] data;
        logic [5:0] index;
        logic       last;
    } rx_result_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_TRICKLE,
        SINK_CHOKE
    } sink_mode_t;

    // per-port frame parser shadow and the queue of results it predicts
    class frame_tracker;
        bit         parse_on;
        pstate_t    phase [PORT_COUNT];
        logic [6:0] want_len [PORT_COUNT];
        logic [6:0] got_len [PORT_COUNT];
        logic [7:0] csum [PORT_COUNT];
        logic [7:0] cmd_byte [PORT_COUNT];
        logic [7:0] payload [PORT_COUNT][PAYLOAD_MAX];
        rx_result_t pending_results [$];
        int         mismatches;
        int         results_seen;
        int         good_frames;
        int         passed_bytes;
        int         longest_frame;

        function new();
            parse_on = 1'b1;
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                phase[p]    = PS_IDLE;
                want_len[p] = '0;
                got_len[p]  = '0;
                csum[p]     = '0;
                cmd_byte[p] = '0;
            end
            mismatches    = 0;
            results_seen  = 0;
            good_frames   = 0;
            passed_bytes  = 0;
            longest_frame = 0;
        endfunction

        function void push_result(logic kind, logic [1:0] port, logic [7:0] command,
                                  logic [6:0] size, logic [7:0] data, logic [5:0] index,
                                  logic last);
            rx_result_t r;
            r.kind    = kind;
            r.port    = port;
            r.command = command;
            r.size    = size;
            r.data    = data;
            r.index   = index;
            r.last    = last;
            pending_results.push_back(r);
        endfunction

        function void take_byte(logic [1:0] port, logic [7:0] b);
            int n;
            if (!parse_on)
            begin
                push_result(KIND_OTHER, port, 8'h00, 7'd0, b, 6'd0, 1'b1);
                passed_bytes++;
                return;
            end
            case (phase[port])
                PS_DOLLAR: phase[port] = (b == CHAR_M) ? PS_M : PS_IDLE;
                PS_M:      phase[port] = (b == CHAR_LT) ? PS_ARROW : PS_IDLE;
                PS_ARROW:
                begin
                    if (b > PAYLOAD_MAX)
                        phase[port] = PS_IDLE;
                    else
                    begin
                        want_len[port] = b[6:0];
                        csum[port]     = b;
                        got_len[port]  = '0;
                        phase[port]    = PS_SIZE;
                    end
                end
                PS_SIZE:
                begin
                    cmd_byte[port] = b;
                    csum[port]     = csum[port] ^ b;
                    phase[port]    = PS_CMD;
                end
                PS_CMD:
                begin
                    if (got_len[port] < want_len[port])
                    begin
                        csum[port] = csum[port] ^ b;
                        payload[port][got_len[port]] = b;
                        got_len[port] = got_len[port] + 7'd1;
                    end
                    else
                    begin
                        phase[port] = PS_IDLE;
                        // checksum byte: a bad one drops the frame without a word
                        if (csum[port] == b)
                        begin
                            n = want_len[port];
                            good_frames++;
                            if (n > longest_frame)
                                longest_frame = n;
                            if (n == 0)
                                push_result(KIND_FRAME, port, cmd_byte[port], 7'd0, 8'h00,
                                            6'd0, 1'b1);
                            for (int i = 0; i < n; i++)
                                push_result(KIND_FRAME, port, cmd_byte[port], 7'(n),
                                            payload[port][i], 6'(i), i == n - 1);
                        end
                    end
                end
                default:
                begin
                    if (b == CHAR_DOLLAR)
                        phase[port] = PS_DOLLAR;
                    else
                    begin
                        phase[port] = PS_IDLE;
                        push_result(KIND_OTHER, port, 8'h00, 7'd0, b, 6'd0, 1'b1);
                        passed_bytes++;
                    end
                end
            endcase
        endfunction

        function string show(rx_result_t r);
            return $sformatf("kind %0d port %0d cmd %02h size %0d byte %02h idx %0d last %0d",
                             r.kind, r.port, r.command, r.size, r.data, r.index, r.last);
        endfunction

        function void match_result(rx_result_t got);
            rx_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] result with nothing pending: %s", $time, show(got));
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.port !== want.port
                || got.command !== want.command || got.size !== want.size
                || got.data !== want.data || got.index !== want.index
                || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] mismatch\n  expected %s\n  actual   %s",
                             $time, show(want), show(got));
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_wr_data   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    frame_tracker tracker = new();
    logic [7:0]   byte_plan [PORT_COUNT][$];
    int           burst_left  = 0;
    int           items_sent  = 0;
    int           cycle_count = 0;

    msp_frame_receiver_unit #(
        .MAX_PAYLOAD(PAYLOAD_MAX),
        .NUM_PORTS  (PORT_COUNT)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, tracker.pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: check every transfer
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_result({m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[9:2],
                                  m_axis_tdata[16:10], m_axis_tdata[24:17],
                                  m_axis_tdata[30:25], m_axis_tlast});
    end

    // sink back-pressure in stretches of differing character
    initial
    begin : sink_stalls
        sink_mode_t mode;
        int         span;
        int         tick;
        tick = 0;
        forever
        begin
            mode = sink_mode_t'($urandom_range(0, 3));
            span = $urandom_range(8, 64);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    SINK_OPEN:    m_axis_tready <= 1'b1;
                    SINK_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                    SINK_TRICKLE: m_axis_tready <= (tick % 3 == 0);
                    default:      m_axis_tready <= ($urandom_range(0, 11) == 0);
                endcase
            end
        end
    end

    // one byte in; returns at the accepting edge, tvalid dropped if a gap follows
    task automatic send_byte(input logic [1:0] port, input logic [7:0] b);
        s_axis_tdata  <= {6'b0, b, port};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.take_byte(port, b);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 10);
        end
    endtask

    // hold the sender until every predicted result has been seen
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending_results.size() != 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_parse_enable(input logic v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.parse_on = v;
    endtask

    // queue a byte sequence for one port: mostly good frames, some broken ones and noise
    function automatic void plan_sequence(input int port, input int forced_len);
        int         pick;
        int         len;
        logic [7:0] cmd;
        logic [7:0] sum;
        logic [7:0] d;
        logic [7:0] bad;
        pick = (forced_len >= 0) ? 0 : $urandom_range(0, 99);
        if (pick >= 90)
        begin
            repeat ($urandom_range(1, 4))
                byte_plan[port].push_back(8'($urandom));
            return;
        end
        byte_plan[port].push_back(CHAR_DOLLAR);
        if (pick >= 82)
        begin
            bad = ($urandom_range(0, 3) == 0) ? CHAR_DOLLAR : 8'($urandom);
            if ($urandom_range(0, 1) == 0)
            begin
                if (bad == CHAR_M)
                    bad = bad ^ 8'h01;
                byte_plan[port].push_back(bad);
            end
            else
            begin
                if (bad == CHAR_LT)
                    bad = bad ^ 8'h01;
                byte_plan[port].push_back(CHAR_M);
                byte_plan[port].push_back(bad);
            end
            return;
        end
        byte_plan[port].push_back(CHAR_M);
        byte_plan[port].push_back(CHAR_LT);
        if (pick >= 75)
        begin
            byte_plan[port].push_back(8'($urandom_range(PAYLOAD_MAX + 1, 255)));
            return;
        end
        if (forced_len >= 0)
            len = forced_len;
        else
        begin
            case ($urandom_range(0, 9))
                7, 8:    len = $urandom_range(7, 20);
                9:       len = $urandom_range(21, PAYLOAD_MAX);
                default: len = $urandom_range(0, 6);
            endcase
        end
        cmd = 8'($urandom);
        sum = 8'(len) ^ cmd;
        byte_plan[port].push_back(8'(len));
        byte_plan[port].push_back(cmd);
        for (int i = 0; i < len; i++)
        begin
            d = 8'($urandom);
            sum = sum ^ d;
            byte_plan[port].push_back(d);
        end
        if (pick >= 65)
            sum = sum ^ 8'($urandom_range(1, 255));
        byte_plan[port].push_back(sum);
    endfunction

    task automatic run_directed();
        // extremes straight through an idle parser
        send_byte(2'd0, 8'h00);
        send_byte(2'd3, 8'hFF);
        // second '$' breaks the header and is dropped, then 'M' and '<' come out as data
        send_byte(2'd2, CHAR_DOLLAR);
        send_byte(2'd2, CHAR_DOLLAR);
        send_byte(2'd2, CHAR_M);
        send_byte(2'd2, CHAR_LT);
        // empty payload
        send_byte(2'd1, CHAR_DOLLAR);
        send_byte(2'd1, CHAR_M);
        send_byte(2'd1, CHAR_LT);
        send_byte(2'd1, 8'h00);
        send_byte(2'd1, 8'hFF);
        send_byte(2'd1, 8'hFF);
        // size one above the limit
        send_byte(2'd0, CHAR_DOLLAR);
        send_byte(2'd0, CHAR_M);
        send_byte(2'd0, CHAR_LT);
        send_byte(2'd0, 8'(PAYLOAD_MAX + 1));
        // one payload byte, wrong checksum
        send_byte(2'd3, CHAR_DOLLAR);
        send_byte(2'd3, CHAR_M);
        send_byte(2'd3, CHAR_LT);
        send_byte(2'd3, 8'h01);
        send_byte(2'd3, 8'h10);
        send_byte(2'd3, 8'hAA);
        send_byte(2'd3, 8'hBA);
        // header left half done across the switch-off
        send_byte(2'd0, CHAR_DOLLAR);
        send_byte(2'd0, CHAR_M);
    endtask

    task automatic run_passthrough(input int count);
        logic [7:0] b;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 7))
                0:       b = CHAR_DOLLAR;
                1:       b = CHAR_M;
                2:       b = CHAR_LT;
                default: b = 8'($urandom);
            endcase
            send_byte(2'($urandom_range(0, PORT_COUNT - 1)), b);
        end
    endtask

    task automatic run_random(input int count);
        int port;
        for (int k = 0; k < count; k++)
        begin
            port = $urandom_range(0, PORT_COUNT - 1);
            // lean towards the longest plan so big frames finish
            if ($urandom_range(0, 9) < 6)
                for (int p = 0; p < PORT_COUNT; p++)
                    if (byte_plan[p].size() > byte_plan[port].size())
                        port = p;
            if (byte_plan[port].size() == 0)
                plan_sequence(port, -1);
            send_byte(2'(port), byte_plan[port].pop_front());
            if (k == count / 2 || $urandom_range(0, 99) == 0)
                drain_block();
        end
    endtask

    initial
    begin : stimulus
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_parse_enable(1'b1);
        run_directed();
        drain_block();
        write_parse_enable(1'b0);
        run_passthrough(OFF_ITEMS);
        drain_block();
        write_parse_enable(1'b1);
        plan_sequence(3, PAYLOAD_MAX);
        run_random(ON_ITEMS);
        drain_block();
        $display("covered %0d input transfers over %0d ports, %0d result transfers checked",
                 items_sent, PORT_COUNT, tracker.results_seen);
        $display("%0d good frames (longest payload %0d bytes), %0d bytes passed through",
                 tracker.good_frames, tracker.longest_frame, tracker.passed_bytes);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

[msp_frame_receiver_unit.f]
+incdir+src
src/msp_rx_pkg.sv
src/msp_rx_ram.sv
src/msp_rx_ctrl.sv
src/msp_rx_datapath.sv
src/msp_frame_receiver_unit.sv
tb/sv/tb_top.sv
